FILE: hw/rtl/pkc_pkg.sv
// Shared constants, codes, tables and types for the position keyed substitution cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package pkc_pkg;

    localparam int ALPHABET_DEPTH = 128;
    localparam int PRIME_COUNT    = 128;
    localparam int KEY_DEPTH      = 64;

    localparam int CHAR_W  = 8;
    localparam int PRIME_W = 11;
    localparam int AIDX_W  = $clog2(ALPHABET_DEPTH);
    localparam int LEN_W   = $clog2(ALPHABET_DEPTH + 1);
    localparam int KIDX_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KLEN_W  = $clog2(KEY_DEPTH + 1);
    localparam int PPOS_W  = $clog2(PRIME_COUNT);
    localparam int BIT_W   = $clog2(PRIME_W);
    localparam int KBIT_W  = $clog2(CHAR_W);

    localparam int ALPHA_INIT_COUNT = 95;
    localparam int ALPHA_INIT_BASE  = 32;
    localparam int ALPHA_LEN_RESET  = 95;

    localparam logic [1:0] CMD_PROCESS  = 2'd0;
    localparam logic [1:0] CMD_ALPHA_WR = 2'd1;
    localparam logic [1:0] CMD_KEY_WR   = 2'd2;

    localparam logic [1:0] CFG_DIRECTION = 2'd0;
    localparam logic [1:0] CFG_ALPHA_LEN = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN   = 2'd2;

    localparam logic [PRIME_W-1:0] PRIME_ROM [PRIME_COUNT] = '{
        11'd1229, 11'd1409, 11'd1867, 11'd1619, 11'd947,  11'd1213, 11'd1459, 11'd1097,
        11'd1663, 11'd1327, 11'd967,  11'd1091, 11'd1847, 11'd1811, 11'd997,  11'd1367,
        11'd1399, 11'd1481, 11'd971,  11'd1483, 11'd1559, 11'd1453, 11'd1051, 11'd1223,
        11'd1087, 11'd1873, 11'd977,  11'd1621, 11'd1531, 11'd1301, 11'd1153, 11'd1823,
        11'd1697, 11'd1381, 11'd1187, 11'd1103, 11'd1787, 11'd1279, 11'd1019, 11'd1699,
        11'd1667, 11'd1657, 11'd1297, 11'd1889, 11'd1289, 11'd1039, 11'd1879, 11'd1013,
        11'd1427, 11'd1009, 11'd1423, 11'd1259, 11'd1871, 11'd1723, 11'd1307, 11'd1163,
        11'd1721, 11'd1447, 11'd1061, 11'd1217, 11'd1741, 11'd1069, 11'd1609, 11'd1523,
        11'd1753, 11'd1553, 11'd1777, 11'd1321, 11'd1049, 11'd1789, 11'd1579, 11'd1303,
        11'd1181, 11'd1021, 11'd1861, 11'd1601, 11'd1031, 11'd1747, 11'd1439, 11'd1831,
        11'd1093, 11'd1319, 11'd1801, 11'd1193, 11'd1063, 11'd1783, 11'd1361, 11'd1109,
        11'd1571, 11'd1171, 11'd1877, 11'd1429, 11'd1237, 11'd1549, 11'd1231, 11'd1499,
        11'd1117, 11'd1669, 11'd1567, 11'd1433, 11'd1277, 11'd1291, 11'd1249, 11'd1733,
        11'd1123, 11'd1033, 11'd1759, 11'd1607, 11'd1471, 11'd1129, 11'd1709, 11'd1283,
        11'd1613, 11'd1201, 11'd1451, 11'd1583, 11'd1637, 11'd1151, 11'd1627, 11'd1487,
        11'd983,  11'd1693, 11'd1373, 11'd1543, 11'd953,  11'd1489, 11'd1493, 11'd1597
    };

    typedef struct packed {
        logic              en;
        logic [AIDX_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } alpha_wr_t;

    typedef struct packed {
        logic              en;
        logic [KIDX_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } key_wr_t;

    // Power-up alphabet: printable ASCII from space upward, zero beyond.
    function automatic logic [CHAR_W-1:0] alpha_init(input logic [AIDX_W-1:0] addr);
        logic [CHAR_W-1:0] v;
        if (32'(addr) < ALPHA_INIT_COUNT)
            v = CHAR_W'(32'(addr) + ALPHA_INIT_BASE);
        else
            v = '0;
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pkc_cond_sub.sv
// Shared modular step: subtract the modulus once when the operand reaches it.
// Depends on pkc_pkg for widths.
`default_nettype none

module pkc_cond_sub
    import pkc_pkg::*;
(
    input  wire logic [LEN_W:0]   a,
    input  wire logic [LEN_W-1:0] m,
    output logic      [LEN_W-1:0] y
);

    logic [LEN_W-1:0] diff;

    assign diff = a[LEN_W-1:0] - m;
    assign y    = (a >= {1'b0, m}) ? diff : a[LEN_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/pkc_alpha_store.sv
// Alphabet memory with per-entry valid bits; unwritten entries read as the power-up alphabet.
// Depends on pkc_pkg (alpha_wr_t, alpha_init).
`default_nettype none

module pkc_alpha_store
    import pkc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire alpha_wr_t         wr,
    input  wire logic [AIDX_W-1:0] rd_addr,
    output logic      [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0]         mem [ALPHABET_DEPTH];
    logic [ALPHABET_DEPTH-1:0] valid_reg;
    logic [CHAR_W-1:0]         mem_q_reg;
    logic [CHAR_W-1:0]         init_q_reg;
    logic                      hit_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg  <= mem[rd_addr];
        init_q_reg <= alpha_init(rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_q_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_q_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_q_reg ? mem_q_reg : init_q_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pkc_key_store.sv
// Key byte memory, one write and one registered read per cycle.
// Depends on pkc_pkg (key_wr_t).
`default_nettype none

module pkc_key_store
    import pkc_pkg::*;
(
    input  wire logic              clk,
    input  wire key_wr_t           wr,
    input  wire logic [KIDX_W-1:0] rd_addr,
    output logic      [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem [KEY_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/position_keyed_substitution_cipher_unit.sv
// Top level: sequencer, configuration registers, positions and output register.
// Depends on pkc_pkg, pkc_cond_sub, pkc_alpha_store, pkc_key_store.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_ready, command, char_value,             | sink
//          | entry_index, first_of_string                         |
//  out     | out_valid, out_ready, out_char, substituted          | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data            | sink
//
// Table writes and unknown commands produce no result and leave the input ready.
// A character is scanned one alphabet entry per cycle through the single memory read
// port, then 11 restoring remainder steps on the prime and, with a key, 8 on the key
// byte, one or two modular adds on the one compare/subtract unit, then a table read.
// Reset clears positions, direction, key length, valid bits; sets alphabet length 95.
// A finished result waits in the output register; new input is taken meanwhile.
`default_nettype none

module position_keyed_substitution_cipher_unit
    import pkc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [CHAR_W-1:0] char_value,
    input  wire logic [6:0]        entry_index,
    input  wire logic              first_of_string,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [CHAR_W-1:0] out_char,
    output logic                   substituted,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MODP,
        ST_MODK,
        ST_ADDP,
        ST_ADDK,
        ST_FETCH,
        ST_LOAD,
        ST_DONE
    } state_t;

    state_t             state_reg,    state_next;
    logic               dir_reg,      dir_next;
    logic [7:0]         alen_reg,     alen_next;
    logic [6:0]         klen_reg,     klen_next;
    logic [PPOS_W-1:0]  ppos_reg,     ppos_next;
    logic [KIDX_W-1:0]  kpos_reg,     kpos_next;
    logic [CHAR_W-1:0]  ch_reg,       ch_next;
    logic [LEN_W-1:0]   len_reg,      len_next;
    logic               has_key_reg,  has_key_next;
    logic [KIDX_W-1:0]  kidx_reg,     kidx_next;
    logic [PRIME_W-1:0] prime_reg,    prime_next;
    logic [LEN_W-1:0]   scan_reg,     scan_next;
    logic [LEN_W-1:0]   x_reg,        x_next;
    logic [LEN_W-1:0]   rem_reg,      rem_next;
    logic [LEN_W-1:0]   p_reg,        p_next;
    logic [LEN_W-1:0]   k_reg,        k_next;
    logic [BIT_W-1:0]   bit_reg,      bit_next;
    logic [CHAR_W-1:0]  res_char_reg, res_char_next;
    logic               res_sub_reg,  res_sub_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_sub_reg,  out_sub_next;
    logic               out_vld_reg,  out_vld_next;

    logic               in_xfer;
    logic [LEN_W-1:0]   len_eff;
    logic [KLEN_W-1:0]  klen_eff;
    logic [PPOS_W-1:0]  ppos_sel;
    logic [KIDX_W-1:0]  kpos_raw;
    logic [KIDX_W-1:0]  kpos_sel;
    logic [KLEN_W-1:0]  kpos_inc;
    logic [LEN_W-1:0]   scan_inc;
    logic [LEN_W-1:0]   offset;
    logic               cur_bit;
    logic [LEN_W:0]     unit_a;
    logic [LEN_W-1:0]   unit_y;
    alpha_wr_t          alpha_wr;
    key_wr_t            key_wr;
    logic [AIDX_W-1:0]  alpha_rd_addr;
    logic [CHAR_W-1:0]  alpha_rd_data;
    logic [CHAR_W-1:0]  key_rd_data;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_vld_reg;
    assign out_char    = out_char_reg;
    assign substituted = out_sub_reg;
    assign in_xfer     = in_valid && in_ready;

    assign len_eff  = (32'(alen_reg) > ALPHABET_DEPTH) ? LEN_W'(ALPHABET_DEPTH)
                                                       : LEN_W'(alen_reg);
    assign klen_eff = (32'(klen_reg) > KEY_DEPTH) ? KLEN_W'(KEY_DEPTH) : KLEN_W'(klen_reg);
    assign ppos_sel = first_of_string ? '0 : ppos_reg;
    assign kpos_raw = first_of_string ? '0 : kpos_reg;
    assign kpos_sel = (KLEN_W'(kpos_raw) >= klen_eff) ? '0 : kpos_raw;
    assign kpos_inc = KLEN_W'(kpos_sel) + KLEN_W'(1);
    assign scan_inc = scan_reg + LEN_W'(1);

    assign alpha_wr.en   = in_xfer && (command == CMD_ALPHA_WR)
                           && (32'(entry_index) < ALPHABET_DEPTH);
    assign alpha_wr.addr = AIDX_W'(entry_index);
    assign alpha_wr.data = char_value;
    assign key_wr.en     = in_xfer && (command == CMD_KEY_WR)
                           && (32'(entry_index) < KEY_DEPTH);
    assign key_wr.addr   = KIDX_W'(entry_index);
    assign key_wr.data   = char_value;

    always_comb
    begin
        case (state_reg)
            ST_SEARCH: alpha_rd_addr = AIDX_W'(scan_inc);
            ST_FETCH:  alpha_rd_addr = AIDX_W'(x_reg);
            default:   alpha_rd_addr = '0;
        endcase
    end

    // Shared unit operand: remainder step during the modulo phases, offset add later.
    always_comb
    begin
        if (state_reg == ST_ADDP)
            offset = dir_reg ? (len_reg - p_reg) : p_reg;
        else
            offset = dir_reg ? (len_reg - k_reg) : k_reg;
        if (state_reg == ST_MODP)
            cur_bit = prime_reg[bit_reg];
        else
            cur_bit = key_rd_data[bit_reg[KBIT_W-1:0]];
        if (state_reg == ST_MODP || state_reg == ST_MODK)
            unit_a = {rem_reg, cur_bit};
        else
            unit_a = {1'b0, x_reg} + {1'b0, offset};
    end

    pkc_cond_sub u_unit (
        .a (unit_a),
        .m (len_reg),
        .y (unit_y)
    );

    pkc_alpha_store u_alpha (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (alpha_wr),
        .rd_addr (alpha_rd_addr),
        .rd_data (alpha_rd_data)
    );

    pkc_key_store u_key (
        .clk     (clk),
        .wr      (key_wr),
        .rd_addr (kidx_reg),
        .rd_data (key_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        dir_next      = dir_reg;
        alen_next     = alen_reg;
        klen_next     = klen_reg;
        ppos_next     = ppos_reg;
        kpos_next     = kpos_reg;
        ch_next       = ch_reg;
        len_next      = len_reg;
        has_key_next  = has_key_reg;
        kidx_next     = kidx_reg;
        prime_next    = prime_reg;
        scan_next     = scan_reg;
        x_next        = x_reg;
        rem_next      = rem_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        bit_next      = bit_reg;
        res_char_next = res_char_reg;
        res_sub_next  = res_sub_reg;
        out_char_next = out_char_reg;
        out_sub_next  = out_sub_reg;
        out_vld_next  = out_vld_reg && !out_ready;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIRECTION: dir_next  = cfg_data[0];
                CFG_ALPHA_LEN: alen_next = cfg_data;
                CFG_KEY_LEN:   klen_next = cfg_data[6:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && command == CMD_PROCESS)
                begin
                    ch_next      = char_value;
                    len_next     = len_eff;
                    has_key_next = (klen_eff != '0);
                    kidx_next    = kpos_sel;
                    prime_next   = PRIME_ROM[ppos_sel];
                    scan_next    = '0;
                    ppos_next    = (32'(ppos_sel) == PRIME_COUNT - 1) ? '0
                                                                      : ppos_sel + PPOS_W'(1);
                    kpos_next    = (kpos_inc >= klen_eff) ? '0 : KIDX_W'(kpos_inc);
                    if (len_eff < LEN_W'(2))
                    begin
                        res_char_next = char_value;
                        res_sub_next  = 1'b0;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (alpha_rd_data == ch_reg)
                begin
                    x_next     = scan_reg;
                    rem_next   = '0;
                    bit_next   = BIT_W'(PRIME_W - 1);
                    state_next = ST_MODP;
                end
                else if (scan_inc == len_reg)
                begin
                    res_char_next = ch_reg;
                    res_sub_next  = 1'b0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    scan_next = scan_inc;
                end
            end
            ST_MODP:
            begin
                rem_next = unit_y;
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    p_next = unit_y;
                    if (has_key_reg)
                    begin
                        rem_next   = '0;
                        bit_next   = BIT_W'(CHAR_W - 1);
                        state_next = ST_MODK;
                    end
                    else
                    begin
                        state_next = ST_ADDP;
                    end
                end
            end
            ST_MODK:
            begin
                rem_next = unit_y;
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    k_next     = unit_y;
                    state_next = ST_ADDP;
                end
            end
            ST_ADDP:
            begin
                x_next     = unit_y;
                state_next = has_key_reg ? ST_ADDK : ST_FETCH;
            end
            ST_ADDK:
            begin
                x_next     = unit_y;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                res_char_next = alpha_rd_data;
                res_sub_next  = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_char_next = res_char_reg;
                    out_sub_next  = res_sub_reg;
                    out_vld_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dir_reg     <= 1'b0;
            alen_reg    <= 8'(ALPHA_LEN_RESET);
            klen_reg    <= '0;
            ppos_reg    <= '0;
            kpos_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            alen_reg    <= alen_next;
            klen_reg    <= klen_next;
            ppos_reg    <= ppos_next;
            kpos_reg    <= kpos_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        len_reg      <= len_next;
        has_key_reg  <= has_key_next;
        kidx_reg     <= kidx_next;
        prime_reg    <= prime_next;
        scan_reg     <= scan_next;
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        bit_reg      <= bit_next;
        res_char_reg <= res_char_next;
        res_sub_reg  <= res_sub_next;
        out_char_reg <= out_char_next;
        out_sub_reg  <= out_sub_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pkc_checker.sv
// Port-level checks for the cipher unit, bound to the top level.
// Depends on pkc_pkg and position_keyed_substitution_cipher_unit.
`default_nettype none

module pkc_checker
    import pkc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [1:0]        command,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CHAR_W-1:0] out_char,
    input wire logic              substituted
);

    // Held result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(substituted))
        else $error("result changed while stalled");

    // Table writes and unknown commands leave the input ready in the cycle after.
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command != CMD_PROCESS |=> in_ready)
        else $error("non-character transfer blocked input");

    // A character makes the block busy in the following cycle.
    a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_PROCESS |=> !in_ready)
        else $error("character transfer did not occupy the block");

    // A new result only appears out of a busy cycle.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work in progress");

endmodule

bind position_keyed_substitution_cipher_unit pkc_checker u_pkc_checker (.*);

`default_nettype wire
